// ===== src/rnc_pkg.sv =====
// Shared constants, codes and controller/datapath link types for the reachable node counter.
`default_nettype none
package rnc_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_ENTRIES = 8192;

  localparam int NODE_W  = 10;                    // node id field width
  localparam int NODE_AW = $clog2(MAX_NODES);     // visited map / stack / head address
  localparam int ENT_AW  = $clog2(MAX_ENTRIES);   // entry memory address
  localparam int PTR_W   = ENT_AW + 1;            // entry pointer incl. empty mark
  localparam int SP_W    = NODE_AW + 1;           // stack pointer, holds MAX_NODES
  localparam int CNT_W   = 11;                    // reached field width
  localparam int NCNT_W  = 11;                    // node_count register width
  localparam int CFG_W   = 11;                    // widest configuration register

  localparam logic [PTR_W-1:0] EMPTY_MARK = PTR_W'(MAX_ENTRIES);
  localparam logic [PTR_W-1:0] FULL_LIMIT = PTR_W'(MAX_ENTRIES - 2);
  localparam logic [SP_W-1:0]  STACK_LIM  = SP_W'(MAX_NODES);

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_EDGE  = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  localparam logic REG_START  = 1'b0;
  localparam logic REG_NCOUNT = 1'b1;

  typedef struct packed {
    logic clr_graph;
    logic head_clr;
    logic vis_clr;
    logic edge_load;
    logic edge_drop;
    logic link_rd;
    logic link_wr;
    logic walk_init;
    logic pop;
    logic head_rd;
    logic ent_rd_head;
    logic ent_rd_next;
    logic vis_rd;
    logic vis_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic edge_ok;
    logic link_last;
    logic start_ok;
    logic sp_zero;
    logic head_empty;
    logic next_empty;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/rnc_if.sv =====
// Valid/ready channel interfaces for the item and result streams.
`default_nettype none
interface rnc_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic [rnc_pkg::NODE_W-1:0] leader;
  logic [rnc_pkg::NODE_W-1:0] member;
  modport source (output valid, output mode, output leader, output member, input ready);
  modport sink   (input valid, input mode, input leader, input member, output ready);
endinterface

interface rnc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rnc_pkg::CNT_W-1:0] reached;
  logic                      overflow;
  modport source (output valid, output reached, output overflow, input ready);
  modport sink   (input valid, input reached, input overflow, output ready);
endinterface
`default_nettype wire

// ===== src/reachable_node_counter.sv =====
// Top level of the reachable node counter: controller, datapath and channel wiring.
`default_nettype none
// A clear item sweeps over the list heads after its accept cycle; the same sweep runs
// once after reset, during which no item is taken. A stored edge item takes the accept
// cycle, then for each direction a read and a rewrite of one list head through the head
// memory's registered read port; a dropped edge is taken without leaving idle. A count
// item clears the visited map, then walks: pop, pop wait and head wait for each node
// popped, then entry wait and visited wait for each adjacency entry followed, all through
// registered memories, then a done state. The result waits in an output register;
// configuration must be written only while idle; the block does not enforce it.
module reachable_node_counter (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  rnc_in_if.sink                          in_if,
  rnc_out_if.source                       out_if,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_idx,
  input  wire logic [rnc_pkg::CFG_W-1:0]  cfg_wdata
);

  rnc_pkg::cmd_t  cmd;
  rnc_pkg::stat_t stat;

  rnc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_mode  (in_if.mode),
    .stat     (stat),
    .in_ready (in_if.ready),
    .cmd      (cmd)
  );

  rnc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_leader    (in_if.leader),
    .in_member    (in_if.member),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_if.ready),
    .out_valid    (out_if.valid),
    .out_reached  (out_if.reached),
    .out_overflow (out_if.overflow)
  );

endmodule
`default_nettype wire

// ===== src/rnc_ctrl.sv =====
// Sequencing state machine: clearing passes, edge linking and the depth first walk.
`default_nettype none
module rnc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_mode,
  input  wire rnc_pkg::stat_t stat,
  output logic               in_ready,
  output rnc_pkg::cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_CLR_HEAD  = 12'b0000_0000_0001,
    S_IDLE      = 12'b0000_0000_0010,
    S_EDGE_RD   = 12'b0000_0000_0100,
    S_EDGE_WR   = 12'b0000_0000_1000,
    S_VIS_CLR   = 12'b0000_0001_0000,
    S_INIT      = 12'b0000_0010_0000,
    S_POP       = 12'b0000_0100_0000,
    S_POP_WAIT  = 12'b0000_1000_0000,
    S_HEAD_WAIT = 12'b0001_0000_0000,
    S_ENT_WAIT  = 12'b0010_0000_0000,
    S_VIS_WAIT  = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR_HEAD: begin
        cmd.head_clr = 1'b1;
        if (stat.idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            rnc_pkg::MODE_CLEAR: begin
              cmd.clr_graph = 1'b1;
              state_nxt     = S_CLR_HEAD;
            end
            rnc_pkg::MODE_EDGE: begin
              if (stat.edge_ok) begin
                cmd.edge_load = 1'b1;
                state_nxt     = S_EDGE_RD;
              end else begin
                cmd.edge_drop = 1'b1;
              end
            end
            rnc_pkg::MODE_COUNT: state_nxt = S_VIS_CLR;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EDGE_RD: begin
        cmd.link_rd = 1'b1;
        state_nxt   = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        cmd.link_wr = 1'b1;
        state_nxt   = stat.link_last ? S_IDLE : S_EDGE_RD;
      end
      S_VIS_CLR: begin
        cmd.vis_clr = 1'b1;
        if (stat.idx_last) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = stat.start_ok ? S_POP : S_DONE;
      end
      S_POP: begin
        if (stat.sp_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        if (stat.head_empty) begin
          state_nxt = S_POP;
        end else begin
          cmd.ent_rd_head = 1'b1;
          state_nxt       = S_ENT_WAIT;
        end
      end
      S_ENT_WAIT: begin
        cmd.vis_rd = 1'b1;
        state_nxt  = S_VIS_WAIT;
      end
      S_VIS_WAIT: begin
        cmd.vis_upd = 1'b1;
        if (stat.next_empty) begin
          state_nxt = S_POP;
        end else begin
          cmd.ent_rd_next = 1'b1;
          state_nxt       = S_ENT_WAIT;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR_HEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR_HEAD;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ===== src/rnc_dp.sv =====
// Datapath: adjacency, visited and stack memories, counters and the result register.
`default_nettype none
module rnc_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rnc_pkg::cmd_t               cmd,
  output rnc_pkg::stat_t                   stat,
  input  wire logic [rnc_pkg::NODE_W-1:0]  in_leader,
  input  wire logic [rnc_pkg::NODE_W-1:0]  in_member,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_idx,
  input  wire logic [rnc_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [rnc_pkg::CNT_W-1:0]        out_reached,
  output logic                             out_overflow
);

  localparam int NW = rnc_pkg::NODE_W;
  localparam int AW = rnc_pkg::NODE_AW;
  localparam int EW = rnc_pkg::ENT_AW;
  localparam int PW = rnc_pkg::PTR_W;
  localparam int SW = rnc_pkg::SP_W;
  localparam int CW = rnc_pkg::CNT_W;

  // memories
  logic [PW-1:0]    head_mem  [rnc_pkg::MAX_NODES];
  logic [NW+PW-1:0] ent_mem   [rnc_pkg::MAX_ENTRIES];
  logic             vis_mem   [rnc_pkg::MAX_NODES];
  logic [NW-1:0]    stack_mem [rnc_pkg::MAX_NODES];

  logic [NW-1:0]              start_r;
  logic [rnc_pkg::NCNT_W-1:0] ncount_r;
  logic [NW-1:0]              lead_r, memb_r;
  logic                       sel_r;
  logic [PW-1:0]              used_r;
  logic                       ovf_r;
  logic [AW-1:0]              idx_r;
  logic [SW-1:0]              sp_r;
  logic [CW-1:0]              cnt_r;
  logic [NW-1:0]              t_r;
  logic [PW-1:0]              next_r;
  logic                       out_valid_r;
  logic [CW-1:0]              out_reached_r;
  logic                       out_ovf_r;

  logic [PW-1:0]    head_q;
  logic [NW+PW-1:0] ent_q;
  logic             vis_q;
  logic [NW-1:0]    stack_q;

  logic [NW-1:0] link_from, link_to;
  logic          new_node, push;

  assign link_from = sel_r ? memb_r : lead_r;
  assign link_to   = sel_r ? lead_r : memb_r;
  assign new_node  = cmd.vis_upd && !vis_q;
  assign push      = new_node && (sp_r < rnc_pkg::STACK_LIM);

  assign stat.idx_last   = &idx_r;
  assign stat.edge_ok    = ({1'b0, in_leader} < ncount_r) && ({1'b0, in_member} < ncount_r)
                           && (used_r <= rnc_pkg::FULL_LIMIT);
  assign stat.link_last  = sel_r;
  assign stat.start_ok   = ({1'b0, start_r} < ncount_r);
  assign stat.sp_zero    = (sp_r == '0);
  assign stat.head_empty = (head_q == rnc_pkg::EMPTY_MARK);
  assign stat.next_empty = (next_r == rnc_pkg::EMPTY_MARK);
  assign stat.out_free   = !out_valid_r || out_ready;

  // list heads: clearing pass or prepend of a new entry
  always_ff @(posedge clk) begin
    if (cmd.head_clr) head_mem[idx_r] <= rnc_pkg::EMPTY_MARK;
    else if (cmd.link_wr) head_mem[AW'(link_from)] <= used_r;
    head_q <= head_mem[cmd.head_rd ? AW'(stack_q) : AW'(link_from)];
  end

  always_ff @(posedge clk) begin
    if (cmd.link_wr) ent_mem[used_r[EW-1:0]] <= {link_to, head_q};
    ent_q <= ent_mem[cmd.ent_rd_head ? head_q[EW-1:0] : next_r[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.vis_clr) vis_mem[idx_r] <= 1'b0;
    else if (cmd.walk_init && stat.start_ok) vis_mem[AW'(start_r)] <= 1'b1;
    else if (new_node) vis_mem[AW'(t_r)] <= 1'b1;
    vis_q <= vis_mem[AW'(ent_q[NW+PW-1:PW])];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init && stat.start_ok) stack_mem['0] <= start_r;
    else if (push) stack_mem[sp_r[AW-1:0]] <= t_r;
    stack_q <= stack_mem[AW'(sp_r - SW'(1))];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.edge_load) begin
      lead_r <= in_leader;
      memb_r <= in_member;
    end
    if (cmd.vis_rd) begin
      t_r    <= ent_q[NW+PW-1:PW];
      next_r <= ent_q[PW-1:0];
    end
    if (cmd.out_load) begin
      out_reached_r <= cnt_r;
      out_ovf_r     <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      ncount_r    <= rnc_pkg::NCNT_W'(rnc_pkg::MAX_NODES);
      sel_r       <= 1'b0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      sp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == rnc_pkg::REG_START)  start_r  <= cfg_wdata[NW-1:0];
      if (cfg_we && cfg_idx == rnc_pkg::REG_NCOUNT) ncount_r <= cfg_wdata;
      if (cmd.head_clr || cmd.vis_clr) idx_r <= idx_r + AW'(1);
      if (cmd.edge_load) sel_r <= 1'b0;
      else if (cmd.link_wr) sel_r <= ~sel_r;
      if (cmd.clr_graph) used_r <= '0;
      else if (cmd.link_wr) used_r <= used_r + PW'(1);
      if (cmd.clr_graph) ovf_r <= 1'b0;
      else if (cmd.edge_drop) ovf_r <= 1'b1;
      if (cmd.walk_init) sp_r <= stat.start_ok ? SW'(1) : '0;
      else if (cmd.pop) sp_r <= sp_r - SW'(1);
      else if (push) sp_r <= sp_r + SW'(1);
      if (cmd.walk_init) cnt_r <= stat.start_ok ? CW'(1) : '0;
      else if (new_node) cnt_r <= cnt_r + CW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_reached  = out_reached_r;
  assign out_overflow = out_ovf_r;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= rnc_pkg::STACK_LIM) else $error("stack pointer beyond depth");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(rnc_pkg::MAX_NODES)) else $error("reach count beyond node total");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= rnc_pkg::EMPTY_MARK) else $error("entry fill beyond storage");
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (used_r == $past(used_r) || used_r == $past(used_r) + PW'(1) || used_r == '0))
    else $error("entry fill moved by more than one");
`endif

endmodule
`default_nettype wire

// ===== test/rnc_checker.sv =====
// Checker for the reachable node counter: watches both channels, predicts counts, compares.
`timescale 1ns / 100ps
`default_nettype none
module rnc_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic [1:0]                 in_mode,
  input  wire logic [rnc_pkg::NODE_W-1:0] in_leader,
  input  wire logic [rnc_pkg::NODE_W-1:0] in_member,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [rnc_pkg::CNT_W-1:0]  out_reached,
  input  wire logic                       out_overflow,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_idx,
  input  wire logic [rnc_pkg::CFG_W-1:0]  cfg_wdata,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [rnc_pkg::CNT_W-1:0] reached;
    logic                      overflow;
  } count_res_t;

  localparam int RES_DEPTH = 16;

  count_res_t                 res_buf[RES_DEPTH];
  int                         res_wr, res_rd;
  logic [rnc_pkg::NODE_W-1:0] start_reg;
  logic [rnc_pkg::NCNT_W-1:0] ncount_reg;
  int                         head[rnc_pkg::MAX_NODES];
  int                         tgt[rnc_pkg::MAX_ENTRIES];
  int                         nxt[rnc_pkg::MAX_ENTRIES];
  int                         used;
  logic                       ovf;

  function automatic int node_lim();
    return (ncount_reg > rnc_pkg::MAX_NODES) ? rnc_pkg::MAX_NODES : int'(ncount_reg);
  endfunction

  task automatic wipe_graph();
    for (int i = 0; i < rnc_pkg::MAX_NODES; i++) head[i] = rnc_pkg::MAX_ENTRIES;
    used = 0;
    ovf  = 1'b0;
  endtask

  task automatic join_nodes(input int a, input int b);
    int lim;
    lim = node_lim();
    if (a >= lim || b >= lim || rnc_pkg::MAX_ENTRIES - used < 2) begin
      ovf = 1'b1;
    end else begin
      tgt[used] = b; nxt[used] = head[a]; head[a] = used; used++;
      tgt[used] = a; nxt[used] = head[b]; head[b] = used; used++;
    end
  endtask

  function automatic int reach_count();
    bit seen[rnc_pkg::MAX_NODES];
    int stk[rnc_pkg::MAX_NODES];
    int sp, n, e, t, cnt;
    for (int i = 0; i < rnc_pkg::MAX_NODES; i++) seen[i] = 1'b0;
    sp = 0;
    if (int'(start_reg) >= node_lim()) return 0;
    seen[start_reg] = 1'b1;
    cnt = 1;
    stk[sp] = int'(start_reg);
    sp++;
    while (sp > 0) begin
      sp--;
      n = stk[sp];
      e = head[n];
      while (e < rnc_pkg::MAX_ENTRIES) begin
        t = tgt[e];
        if (!seen[t]) begin
          seen[t] = 1'b1;
          cnt++;
          if (sp < rnc_pkg::MAX_NODES) begin
            stk[sp] = t;
            sp++;
          end
        end
        e = nxt[e];
      end
    end
    return cnt;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    res_wr     = 0;
    res_rd     = 0;
    start_reg  = '0;
    ncount_reg = rnc_pkg::NCNT_W'(1024);
    wipe_graph();
  end

  always @(posedge clk) begin
    count_res_t r, got;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_idx == rnc_pkg::REG_START) start_reg = cfg_wdata[rnc_pkg::NODE_W-1:0];
        else ncount_reg = cfg_wdata[rnc_pkg::NCNT_W-1:0];
      end
      if (in_valid && in_ready) begin
        case (in_mode)
          rnc_pkg::MODE_CLEAR: wipe_graph();
          rnc_pkg::MODE_EDGE:  join_nodes(int'(in_leader), int'(in_member));
          rnc_pkg::MODE_COUNT: begin
            r.reached  = rnc_pkg::CNT_W'(reach_count());
            r.overflow = ovf;
            res_buf[res_wr % RES_DEPTH] = r;
            res_wr++;
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{out_reached, out_overflow};
        if (res_wr == res_rd) begin
          $display("%0t: unexpected result reached=%0d overflow=%0b",
                   $time, out_reached, out_overflow);
          fail_count++;
        end else begin
          r = res_buf[res_rd % RES_DEPTH];
          res_rd++;
          if (got.reached !== r.reached)
            $display("%0t: reached expected %0d actual %0d", $time, r.reached, got.reached);
          if (got.overflow !== r.overflow)
            $display("%0t: overflow expected %0b actual %0b", $time, r.overflow, got.overflow);
          if (got !== r) fail_count++;
        end
      end
      pending = res_wr - res_rd;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench top for the reachable node counter: stimulus, configuration and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [rnc_pkg::CFG_W-1:0] cfg_wdata;
  int   fail_count, pending;
  int   in_idle, out_idle;
  longint cycles;

  rnc_in_if  in_ch();
  rnc_out_if out_ch();

  reachable_node_counter DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  rnc_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
    .in_leader(in_ch.leader), .in_member(in_ch.member),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_reached(out_ch.reached), .out_overflow(out_ch.overflow),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stall, plus run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ch.ready <= ($urandom_range(99) >= out_idle);
    if (cycles > 64'd3000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Valid stays high after a transfer; the next item or an idle cycle replaces it
  task automatic send(input logic [1:0] m, input int a, input int b);
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= m;
    in_ch.leader <= rnc_pkg::NODE_W'(a);
    in_ch.member <= rnc_pkg::NODE_W'(b);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= rnc_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random item, mostly edges among a small node set
  task automatic rand_item(input int span);
    int k;
    k = $urandom_range(99);
    if (k < 2) send(rnc_pkg::MODE_CLEAR, $urandom, $urandom);
    else if (k < 4) send(MODE_SPARE, $urandom, $urandom);
    else if (k < 14) send(rnc_pkg::MODE_COUNT, $urandom, $urandom);
    else if (k < 18) send(rnc_pkg::MODE_EDGE, $urandom, $urandom);
    else send(rnc_pkg::MODE_EDGE, $urandom_range(span - 1), $urandom_range(span - 1));
  endtask

  initial begin
    cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = 1'b0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.mode = '0; in_ch.leader = '0; in_ch.member = '0;
    out_ch.ready = 1'b0;
    in_idle = 0; out_idle = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty graph, extremes, self loop, mode 3, range checks
    send(rnc_pkg::MODE_COUNT, 0, 0);
    send(rnc_pkg::MODE_EDGE, 0, 1023);
    send(rnc_pkg::MODE_EDGE, 5, 5);
    send(rnc_pkg::MODE_EDGE, 1023, 1);
    send(MODE_SPARE, 1023, 1023);
    send(rnc_pkg::MODE_COUNT, 0, 0);
    write_reg(rnc_pkg::REG_START, 1023);
    send(rnc_pkg::MODE_COUNT, 0, 0);
    write_reg(rnc_pkg::REG_NCOUNT, 1000);
    send(rnc_pkg::MODE_COUNT, 0, 0);
    send(rnc_pkg::MODE_EDGE, 0, 1010);
    write_reg(rnc_pkg::REG_START, 0);
    send(rnc_pkg::MODE_COUNT, 0, 0);
    write_reg(rnc_pkg::REG_NCOUNT, 1);
    send(rnc_pkg::MODE_EDGE, 0, 0);
    send(rnc_pkg::MODE_EDGE, 0, 1);
    send(rnc_pkg::MODE_COUNT, 0, 0);
    send(rnc_pkg::MODE_CLEAR, 0, 0);
    send(rnc_pkg::MODE_COUNT, 0, 0);
    write_reg(rnc_pkg::REG_NCOUNT, 2047);
    write_reg(rnc_pkg::REG_START, 5);
    send(rnc_pkg::MODE_EDGE, 5, 6);
    send(rnc_pkg::MODE_COUNT, 0, 0);

    for (int ph = 0; ph < 3; ph++) begin
      in_idle  = (ph == 0) ? 12 : (ph == 1) ? 60 : 0;
      out_idle = (ph == 0) ? 60 : (ph == 1) ? 12 : 0;
      write_reg(rnc_pkg::REG_NCOUNT, (ph == 1) ? 24 : 1024);
      write_reg(rnc_pkg::REG_START, $urandom_range(15));
      send(rnc_pkg::MODE_CLEAR, 0, 0);
      for (int i = 0; i < 190; i++) begin
        rand_item((ph == 2) ? 64 : 24);
        if (i == 90) drain();
      end
    end

    // Long edge burst over the whole node range
    in_idle = 0; out_idle = 0;
    write_reg(rnc_pkg::REG_NCOUNT, 1024);
    write_reg(rnc_pkg::REG_START, 0);
    send(rnc_pkg::MODE_CLEAR, 0, 0);
    for (int i = 0; i < 150; i++)
      send(rnc_pkg::MODE_EDGE, $urandom_range(1023), $urandom_range(1023));
    send(rnc_pkg::MODE_COUNT, 0, 0);
    send(rnc_pkg::MODE_CLEAR, 0, 0);
    send(rnc_pkg::MODE_COUNT, 0, 0);

    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
